>>> design/assert_macros.svh
// Assertion macros shared by the thermal smoother RTL.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset
`define TFSA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tfsa assertion failed");
// Condition in one cycle implies a condition in the next cycle
`define TFSA_ASSERT_NEXT(label, cond, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (post)) \
    else $error("tfsa assertion failed");
`else
`define TFSA_ASSERT(label, prop)
`define TFSA_ASSERT_NEXT(label, cond, post)
`endif
`endif

>>> design/tfsa_pkg.sv
// Package for the thermal frame smoother: beat types, config register map,
// reset values and the 16-bit saturation helper. No dependencies.
`timescale 1ns / 1ps

package tfsa_pkg;

  // input beat: one raw pixel
  typedef struct packed {
    logic signed [15:0] sample;
    logic               frame_end;
  } in_beat_t;

  // output beat: smoothed pixel plus display range on the last pixel
  typedef struct packed {
    logic signed [15:0] smoothed;
    logic               range_valid;
    logic signed [15:0] range_min;
    logic signed [15:0] range_max;
  } out_beat_t;

  // configuration register contents
  typedef struct packed {
    logic        [7:0]  smoothing_alpha;
    logic signed [15:0] valid_low;
    logic signed [15:0] valid_high;
    logic        [14:0] min_span;
    logic        [14:0] max_span;
    logic signed [15:0] empty_min;
    logic signed [15:0] empty_max;
  } cfg_t;

  // pipeline moves, shared between the stage modules
  typedef struct packed {
    logic load;   // beat accepted into stage 1
    logic adv1;   // stage 1 -> stage 2
    logic adv2;   // stage 2 -> stage 3
    logic adv3;   // stage 3 -> output register
  } pipe_ctl_t;

  // register map, word index = paddr[4:2]
  localparam int unsigned CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_ALPHA      = 3'd0,
    REG_VALID_LOW  = 3'd1,
    REG_VALID_HIGH = 3'd2,
    REG_MIN_SPAN   = 3'd3,
    REG_MAX_SPAN   = 3'd4,
    REG_EMPTY_MIN  = 3'd5,
    REG_EMPTY_MAX  = 3'd6
  } reg_idx_t;

  localparam cfg_t CFG_RESET = '{
    smoothing_alpha: 8'd179,
    valid_low:       -16'sd640,
    valid_high:      16'sd4800,
    min_span:        15'd80,
    max_span:        15'd1600,
    empty_min:       16'sd4800,
    empty_max:       -16'sd640
  };

  // clamp a 19-bit signed value into 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sh7fff;
    end else if (v < -19'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

>>> design/thermal_frame_smooth_autorange.sv
// Thermal frame smoother with display autorange, top level.
// Input beat: one raw pixel (in_data.sample, in_data.frame_end) in raster order.
// Output beat: the smoothed pixel; on the frame_end pixel also range_valid
// and the display range (range_min, range_max), otherwise those are zero.
// Each pixel is blended with the stored value of the same position:
// (old*alpha + raw*(256-alpha) + 128) >> 8, and written back to the store.
// Path: a beat accepted into stage 1 passes the store read, min/max, range
// adjust and the output register, in that order, before it shows on out_*.
// Throughput: one pixel per cycle when not stalled; the store has one RAM read
// and one write port, read for the next pixel while the previous is written back.
// Receiver stall: the output register holds, stages fill behind it, and
// in_ready drops only when every stage is occupied.
// Reset (synchronous rst_n): registers take their reset values, the pixel
// index goes to zero and the store reads as zero until each entry is
// rewritten; no clearing pass, pixels are accepted right after reset.
// User must write configuration registers via the APB port only while idle; unenforced.
// Depends on tfsa_pkg, tfsa_cfg, tfsa_blend, tfsa_range, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module thermal_frame_smooth_autorange import tfsa_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = 32,
  parameter int unsigned FRAME_HEIGHT = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;

  cfg_t      cfg;
  pipe_ctl_t ctl;
  out_beat_t result;

  logic signed [15:0] s2_smoothed;
  logic               s2_frame_end;

  logic      v1_r;
  logic      v2_r;
  logic      v3_r;
  logic      out_valid_r;
  out_beat_t out_data_r;

  logic rdy_o;
  logic rdy3;
  logic rdy2;
  logic rdy1;

  // per-stage ready chain from the output register back to the input
  assign rdy_o    = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || rdy_o;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign ctl.load = in_valid && rdy1;
  assign ctl.adv1 = v1_r && rdy2;
  assign ctl.adv2 = v2_r && rdy3;
  assign ctl.adv3 = v3_r && rdy_o;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.load) begin
        v1_r <= 1'b1;
      end else if (ctl.adv1) begin
        v1_r <= 1'b0;
      end
      if (ctl.adv1) begin
        v2_r <= 1'b1;
      end else if (ctl.adv2) begin
        v2_r <= 1'b0;
      end
      if (ctl.adv2) begin
        v3_r <= 1'b1;
      end else if (ctl.adv3) begin
        v3_r <= 1'b0;
      end
      if (ctl.adv3) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.adv3) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tfsa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tfsa_blend #(
    .PIXEL_COUNT(PIXEL_COUNT)
  ) u_blend (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .in_data      (in_data),
    .alpha        (cfg.smoothing_alpha),
    .s2_smoothed  (s2_smoothed),
    .s2_frame_end (s2_frame_end)
  );

  tfsa_range u_range (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .cfg          (cfg),
    .s2_smoothed  (s2_smoothed),
    .s2_frame_end (s2_frame_end),
    .result       (result)
  );

  // checks
  `TFSA_ASSERT(a_ready_when_out_empty, !out_valid |-> in_ready)
  `TFSA_ASSERT(a_full_stall_blocks_input, (out_valid && !out_ready && v1_r && v2_r && v3_r) |-> !in_ready)
  `TFSA_ASSERT(a_range_ordered, (out_valid && out_data.range_valid) |-> (out_data.range_min <= out_data.range_max))
  `TFSA_ASSERT(a_range_zero_mid_frame, (out_valid && !out_data.range_valid) |-> (out_data.range_min == 16'sd0 && out_data.range_max == 16'sd0))
  `TFSA_ASSERT_NEXT(a_stage3_moves_out, v3_r && !out_valid, out_valid)

endmodule

>>> design/tfsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module tfsa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 768,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/tfsa_cfg.sv
// APB-style configuration registers of the thermal smoother.
// Depends on tfsa_pkg (cfg_t, register map, reset values).
`timescale 1ns / 1ps

module tfsa_cfg import tfsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // write decode; addresses past the map are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_ALPHA:      cfg_nxt.smoothing_alpha = pwdata[7:0];
        REG_VALID_LOW:  cfg_nxt.valid_low       = pwdata[15:0];
        REG_VALID_HIGH: cfg_nxt.valid_high      = pwdata[15:0];
        REG_MIN_SPAN:   cfg_nxt.min_span        = pwdata[14:0];
        REG_MAX_SPAN:   cfg_nxt.max_span        = pwdata[14:0];
        REG_EMPTY_MIN:  cfg_nxt.empty_min       = pwdata[15:0];
        REG_EMPTY_MAX:  cfg_nxt.empty_max       = pwdata[15:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux, signed registers sign-extended
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ALPHA:      prdata = {24'd0, cfg_r.smoothing_alpha};
      REG_VALID_LOW:  prdata = {{16{cfg_r.valid_low[15]}}, cfg_r.valid_low};
      REG_VALID_HIGH: prdata = {{16{cfg_r.valid_high[15]}}, cfg_r.valid_high};
      REG_MIN_SPAN:   prdata = {17'd0, cfg_r.min_span};
      REG_MAX_SPAN:   prdata = {17'd0, cfg_r.max_span};
      REG_EMPTY_MIN:  prdata = {{16{cfg_r.empty_min[15]}}, cfg_r.empty_min};
      REG_EMPTY_MAX:  prdata = {{16{cfg_r.empty_max[15]}}, cfg_r.empty_max};
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> design/tfsa_blend.sv
// Pixel blend stage: pixel index, frame store RAM with fill count and
// write-back forwarding, and the alpha blend. Depends on tfsa_pkg, tfsa_ram.
`timescale 1ns / 1ps

module tfsa_blend import tfsa_pkg::*; #(
  parameter int unsigned PIXEL_COUNT = 768
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pipe_ctl_t          ctl,
  input  in_beat_t           in_data,
  input  logic [7:0]         alpha,
  output logic signed [15:0] s2_smoothed,
  output logic               s2_frame_end
);

  localparam int unsigned IDX_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned FILL_W = $clog2(PIXEL_COUNT + 1);

  // index and high-water mark of written entries (control state)
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;

  // stage 1 payload
  logic [IDX_W-1:0]   s1_idx_r;
  logic signed [15:0] s1_sample_r;
  logic               s1_fe_r;
  logic               s1_fwd_r;
  logic signed [15:0] s1_fwd_val_r;
  logic               s1_ram_ok_r;

  // stage 2 payload
  logic signed [15:0] s2_sm_r;
  logic               s2_fe_r;

  logic               fwd;
  logic               old_ok;
  logic               idx_last;
  logic [15:0]        ram_rdata;
  logic signed [15:0] old_val;
  logic signed [16:0] diff;
  logic signed [8:0]  alpha_s;
  logic signed [25:0] prod;
  logic signed [26:0] acc;
  logic signed [15:0] sm1;

  // entries below the fill mark have been written since reset
  assign old_ok   = FILL_W'(idx_r) < fill_r;
  // same entry still being written back by the beat in stage 1
  assign fwd      = ctl.load && ctl.adv1 && (s1_idx_r == idx_r);
  assign idx_last = (idx_r == IDX_W'(PIXEL_COUNT - 1));
  assign idx_nxt  = (in_data.frame_end || idx_last) ? '0 : idx_r + 1'b1;
  assign fill_nxt = (FILL_W'(idx_r) == fill_r) ? fill_r + 1'b1 : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      fill_r <= '0;
    end else if (ctl.load) begin
      idx_r  <= idx_nxt;
      fill_r <= fill_nxt;
    end
  end

  // stage 1 load: read issued this cycle, data arrives with the stage
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      s1_idx_r     <= idx_r;
      s1_sample_r  <= in_data.sample;
      s1_fe_r      <= in_data.frame_end;
      s1_fwd_r     <= fwd;
      s1_fwd_val_r <= sm1;
      s1_ram_ok_r  <= old_ok;
    end
  end

  tfsa_ram #(
    .WIDTH(16),
    .DEPTH(PIXEL_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ctl.adv1),
    .waddr (s1_idx_r),
    .wdata (sm1),
    .re    (ctl.load),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // previous smoothed value: forwarded, stored, or zero if never written
  always_comb begin
    if (s1_fwd_r) begin
      old_val = s1_fwd_val_r;
    end else if (s1_ram_ok_r) begin
      old_val = ram_rdata;
    end else begin
      old_val = '0;
    end
  end

  // old*a + raw*(256-a) = raw*256 + (old-raw)*a, rounded, floored
  assign diff    = {old_val[15], old_val} - {s1_sample_r[15], s1_sample_r};
  assign alpha_s = {1'b0, alpha};
  assign prod    = diff * alpha_s;
  assign acc     = {prod[25], prod} + {{3{s1_sample_r[15]}}, s1_sample_r, 8'h00}
                   + 27'sd128;
  assign sm1     = sat16(acc[26:8]);

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      s2_sm_r <= sm1;
      s2_fe_r <= s1_fe_r;
    end
  end

  assign s2_smoothed  = s2_sm_r;
  assign s2_frame_end = s2_fe_r;

endmodule

>>> design/tfsa_range.sv
// Running min/max over the valid window and display range adjustment.
// Depends on tfsa_pkg (cfg_t, out_beat_t, pipe_ctl_t, sat16).
`timescale 1ns / 1ps

module tfsa_range import tfsa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  pipe_ctl_t          ctl,
  input  cfg_t               cfg,
  input  logic signed [15:0] s2_smoothed,
  input  logic               s2_frame_end,
  output out_beat_t          result
);

  logic signed [15:0] run_min_r;
  logic signed [15:0] run_max_r;

  logic signed [15:0] s3_sm_r;
  logic               s3_fe_r;
  logic signed [15:0] s3_lo_r;
  logic signed [15:0] s3_hi_r;

  logic               in_win;
  logic signed [15:0] lo2;
  logic signed [15:0] hi2;

  logic signed [16:0] span;
  logic signed [16:0] mn17;
  logic signed [16:0] mx17;
  logic               wide;
  logic               narrow;
  logic signed [16:0] hi_wid;
  logic signed [17:0] sum_w;
  logic signed [18:0] dlo;
  logic signed [18:0] dhi;
  logic signed [15:0] lo_n;
  logic signed [15:0] hi_n;
  logic signed [15:0] lo_f;
  logic signed [15:0] hi_f;

  // stage 2: fold this pixel into the running extremes
  assign in_win = (s2_smoothed >= cfg.valid_low) && (s2_smoothed <= cfg.valid_high);
  assign lo2    = (in_win && (s2_smoothed < run_min_r)) ? s2_smoothed : run_min_r;
  assign hi2    = (in_win && (s2_smoothed > run_max_r)) ? s2_smoothed : run_max_r;

  // extremes restart from the empty values after the last pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_r <= CFG_RESET.empty_min;
      run_max_r <= CFG_RESET.empty_max;
    end else if (ctl.adv2) begin
      if (s2_frame_end) begin
        run_min_r <= cfg.empty_min;
        run_max_r <= cfg.empty_max;
      end else begin
        run_min_r <= lo2;
        run_max_r <= hi2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      s3_sm_r <= s2_smoothed;
      s3_fe_r <= s2_frame_end;
      s3_lo_r <= lo2;
      s3_hi_r <= hi2;
    end
  end

  // stage 3: widen to min_span, then narrow to max_span about the center
  assign mn17   = {2'b00, cfg.min_span};
  assign mx17   = {2'b00, cfg.max_span};
  assign span   = {s3_hi_r[15], s3_hi_r} - {s3_lo_r[15], s3_lo_r};
  assign wide   = span < mn17;
  assign narrow = wide ? (mn17 > mx17) : (span > mx17);
  assign hi_wid = {s3_lo_r[15], s3_lo_r} + mn17;
  assign sum_w  = wide ? ({s3_lo_r[15], s3_lo_r, 1'b0} + {3'b000, cfg.min_span})
                       : ({{2{s3_lo_r[15]}}, s3_lo_r} + {{2{s3_hi_r[15]}}, s3_hi_r});

  // low = floor((sum - max)/2), high = low + max = floor((sum + max)/2)
  assign dlo  = {sum_w[17], sum_w} - {4'b0000, cfg.max_span};
  assign dhi  = {sum_w[17], sum_w} + {4'b0000, cfg.max_span};
  assign lo_n = sat16({dlo[18], dlo[18:1]});
  assign hi_n = sat16({dhi[18], dhi[18:1]});

  always_comb begin
    if (narrow) begin
      lo_f = lo_n;
      hi_f = hi_n;
    end else if (wide) begin
      lo_f = s3_lo_r;
      hi_f = sat16({{2{hi_wid[16]}}, hi_wid});
    end else begin
      lo_f = s3_lo_r;
      hi_f = s3_hi_r;
    end
  end

  // range fields only carry data on the last pixel
  always_comb begin
    result.smoothed    = s3_sm_r;
    result.range_valid = s3_fe_r;
    result.range_min   = s3_fe_r ? lo_f : 16'sd0;
    result.range_max   = s3_fe_r ? hi_f : 16'sd0;
  end

endmodule
